### rtl/phased_array_focus_pattern_defines.svh
// assertion macros used by the rtl
`ifndef PHASED_ARRAY_FOCUS_PATTERN_DEFINES_SVH
`define PHASED_ARRAY_FOCUS_PATTERN_DEFINES_SVH

// same-cycle implication
`define PAFP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PAFP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/pafp_pkg.sv
`default_nettype none
package pafp_pkg;

    localparam int COLUMNS     = 8;
    localparam int ROWS        = 4;
    localparam int PHASE_STEPS = 10;
    localparam int CELLS       = COLUMNS * ROWS;
    localparam int ADDR_W      = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int IDX_W       = 3;

    // floor(2^33 / 86) for the divide by 86
    localparam logic [26:0] RECIP_86 = 27'd99882960;
    localparam int          RECIP_SH = 33;

    typedef enum logic [1:0] {
        CMD_SET   = 2'd0,
        CMD_FOCUS = 2'd1,
        CMD_FLAT  = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        REG_DIAMETER = 2'd0,
        REG_SPACING  = 2'd1
    } t_reg;

    function automatic logic [12:0] centre_of(input logic [7:0] d, input logic [7:0] s,
                                              input logic [IDX_W-1:0] idx);
        logic [12:0] pitch;
        pitch = 13'(d) + 13'(s);
        return 13'({1'b0, d[7:1]}) + 13'(pitch * 13'(idx));
    endfunction

    function automatic logic [4:0] steps_of(input logic [7:0] v);
        logic [12:0] x;
        x = 13'(v) * 13'(PHASE_STEPS);
        return 5'((x + (x >> 8) + 13'd1) >> 8);
    endfunction

    function automatic logic [15:0] make_pattern(input logic [7:0] phase,
                                                 input logic [7:0] duty);
        logic [4:0]  np;
        logic [4:0]  nd;
        logic [4:0]  zeros;
        logic [4:0]  start;
        logic [16:0] pat;
        logic [16:0] mask;
        np   = steps_of(phase);
        nd   = steps_of(duty);
        mask = (17'd1 << PHASE_STEPS) - 17'd1;
        if ((6'(np) + 6'(nd)) > 6'(PHASE_STEPS)) begin
            zeros = 5'(PHASE_STEPS) - nd;
            start = np + nd - 5'(PHASE_STEPS);
            pat   = ~(((17'd1 << zeros) - 17'd1) << start);
        end else begin
            pat = ((17'd1 << nd) - 17'd1) << np;
        end
        return 16'(pat & mask);
    endfunction

endpackage
`default_nettype wire

### rtl/pafp_isqrt.sv
`default_nettype none
module pafp_isqrt (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [31:0] i_radicand,
    output logic             o_done,
    output logic [15:0]      o_root
);

    logic        r_busy;
    logic        r_done;
    logic [3:0]  r_cnt;
    logic [31:0] r_n;
    logic [31:0] r_res;
    logic [31:0] r_bit;
    logic [31:0] trial;

    assign trial = r_res + r_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 4'd1;
                if (r_cnt == 4'd15) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // one result bit per cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_n   <= i_radicand;
            r_res <= '0;
            r_bit <= 32'h4000_0000;
        end else if (r_busy) begin
            if (r_n >= trial) begin
                r_n   <= r_n - trial;
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign o_done = r_done;
    assign o_root = r_res[15:0];

endmodule
`default_nettype wire

### rtl/phased_array_focus_pattern.sv
// set: result registered one cycle after the request, next request taken two cycles after it
// focus: 32 results, 24 cycles each, 17 of them waiting on the 16-step square root unit
// flat: 32 results, 3 cycles each; one command in flight at a time
// a full output register holds back the sequencer until taken
// synchronous active-low reset clears the offset table valid bits and config
`default_nettype none
`include "phased_array_focus_pattern_defines.svh"
module phased_array_focus_pattern (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_addr,
    input  wire logic [7:0]  i_cfg_wdata,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    // command, column_index, row_index, offset_value, duty_level, focus_px,
    // focus_py, focus_pz, zero pad
    input  wire logic [63:0] i_s_tdata,
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    // out_column, out_row, wave_pattern, zero pad
    output logic [23:0]      o_m_tdata,
    // status
    output logic             o_m_tuser,
    output logic             o_m_tlast
);

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_ELEM = 9'b000000010,
        S_SQX  = 9'b000000100,
        S_SQY  = 9'b000001000,
        S_X100 = 9'b000010000,
        S_SQRT = 9'b000100000,
        S_MUL  = 9'b001000000,
        S_DIV  = 9'b010000000,
        S_OUT  = 9'b100000000
    } t_state;

    localparam logic [6:0] DIV_K = 7'd86;
    localparam int ADDR_W_L = pafp_pkg::ADDR_W;

    t_state r_state, n_state;

    logic [7:0] r_diam, r_space;

    logic [1:0] in_cmd;
    logic [7:0] in_col, in_row, in_off, in_duty, in_px, in_py, in_pz;
    assign in_cmd  = i_s_tdata[1:0];
    assign in_col  = i_s_tdata[9:2];
    assign in_row  = i_s_tdata[17:10];
    assign in_off  = i_s_tdata[25:18];
    assign in_duty = i_s_tdata[33:26];
    assign in_px   = i_s_tdata[41:34];
    assign in_py   = i_s_tdata[49:42];
    assign in_pz   = i_s_tdata[57:50];

    logic       acc, set_bad, wr_en;
    logic [ADDR_W_L-1:0] wr_addr;

    assign o_s_tready = (r_state == S_IDLE);
    assign acc        = i_s_tvalid && o_s_tready;
    assign set_bad    = (int'(in_col) >= pafp_pkg::COLUMNS) || (int'(in_row) >= pafp_pkg::ROWS);
    assign wr_en      = acc && (in_cmd == pafp_pkg::CMD_SET) && !set_bad;
    assign wr_addr    = ADDR_W_L'(int'(in_col) * pafp_pkg::ROWS + int'(in_row));

    // offset table with per-entry valid bits
    logic [7:0] r_mem [pafp_pkg::CELLS];
    logic [pafp_pkg::CELLS-1:0] r_vld;
    logic [7:0] r_rd_data;
    logic       r_rd_vld;
    logic [ADDR_W_L-1:0] rd_addr;

    logic [pafp_pkg::IDX_W-1:0] r_x, r_y;
    assign rd_addr = ADDR_W_L'(int'(r_x) * pafp_pkg::ROWS + int'(r_y));

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= in_off;
        end
        if (r_state == S_ELEM) begin
            r_rd_data <= r_mem[rd_addr];
            r_rd_vld  <= r_vld[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (wr_en) begin
            r_vld[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_diam  <= 8'd16;
            r_space <= 8'd2;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                pafp_pkg::REG_DIAMETER: r_diam  <= i_cfg_wdata;
                pafp_pkg::REG_SPACING:  r_space <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // request fields
    logic [1:0]  r_cmd;
    logic        r_bad;
    logic [7:0]  r_col, r_row, r_duty, r_px, r_py;
    logic [15:0] r_pz2;

    // per-element datapath
    logic signed [13:0] r_dx, r_dy;
    logic [24:0]        r_sum;
    logic [7:0]         r_off, r_phase;
    logic [23:0]        r_v;
    logic [50:0]        r_prod;

    logic        sq_start, sq_done;
    logic [15:0] sq_root;
    logic [31:0] sq_rad;

    logic signed [27:0] sq_x, sq_y;
    logic [12:0]        cx, cy;
    logic [7:0]         off_sel;
    logic [17:0]        q_est;
    logic [24:0]        rem;
    logic [7:0]         q_lo;
    logic               last_elem, out_load;

    assign cx        = pafp_pkg::centre_of(r_diam, r_space, r_x);
    assign cy        = pafp_pkg::centre_of(r_diam, r_space, r_y);
    assign sq_x      = r_dx * r_dx;
    assign sq_y      = r_dy * r_dy;
    assign off_sel   = r_rd_vld ? r_rd_data : 8'd0;
    assign sq_rad    = (32'(r_sum) << 6) + (32'(r_sum) << 5) + (32'(r_sum) << 2);
    assign sq_start  = (r_state == S_X100);
    assign q_est     = r_prod[50:pafp_pkg::RECIP_SH];
    assign rem       = 25'(r_v) - 25'(q_est) * 25'(DIV_K);
    assign q_lo      = (rem >= 25'(DIV_K)) ? (q_est[7:0] + 8'd1) : q_est[7:0];
    assign last_elem = (int'(r_x) == pafp_pkg::COLUMNS - 1) && (int'(r_y) == pafp_pkg::ROWS - 1);
    assign out_load  = (r_state == S_OUT) && (!o_m_tvalid || i_m_tready);

    pafp_isqrt u_isqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (sq_start),
        .i_radicand (sq_rad),
        .o_done     (sq_done),
        .o_root     (sq_root)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (acc) begin
                    case (in_cmd)
                        pafp_pkg::CMD_SET:                     n_state = S_OUT;
                        pafp_pkg::CMD_FOCUS, pafp_pkg::CMD_FLAT: n_state = S_ELEM;
                        default:                               n_state = S_IDLE;
                    endcase
                end
            end
            S_ELEM: n_state = S_SQX;
            S_SQX:  n_state = (r_cmd == pafp_pkg::CMD_FLAT) ? S_OUT : S_SQY;
            S_SQY:  n_state = S_X100;
            S_X100: n_state = S_SQRT;
            S_SQRT: n_state = sq_done ? S_MUL : S_SQRT;
            S_MUL:  n_state = S_DIV;
            S_DIV:  n_state = S_OUT;
            S_OUT: begin
                if (out_load) begin
                    if (r_cmd == pafp_pkg::CMD_SET || last_elem) begin
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_ELEM;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            o_m_tvalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                o_m_tvalid <= 1'b1;
            end else if (i_m_tready) begin
                o_m_tvalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_cmd  <= in_cmd;
            r_bad  <= set_bad;
            r_col  <= in_col;
            r_row  <= in_row;
            r_duty <= in_duty;
            r_px   <= in_px;
            r_py   <= in_py;
            r_pz2  <= 16'(in_pz) * 16'(in_pz);
            r_x    <= '0;
            r_y    <= '0;
        end
        case (r_state)
            S_ELEM: begin
                r_dx <= $signed({1'b0, cx}) - $signed({6'd0, r_px});
                r_dy <= $signed({1'b0, cy}) - $signed({6'd0, r_py});
            end
            S_SQX: begin
                r_off   <= off_sel;
                r_phase <= off_sel;
                r_sum   <= 25'(r_pz2) + 25'(sq_x[23:0]);
            end
            S_SQY:  r_sum  <= r_sum + 25'(sq_y[23:0]);
            S_SQRT: r_v    <= (24'(sq_root) << 8) - 24'(sq_root);
            S_MUL:  r_prod <= 51'(r_v) * 51'(pafp_pkg::RECIP_86);
            S_DIV:  r_phase <= q_lo + r_off;
            S_OUT: begin
                if (out_load && r_cmd != pafp_pkg::CMD_SET) begin
                    if (int'(r_y) == pafp_pkg::ROWS - 1) begin
                        r_y <= '0;
                        r_x <= r_x + 1'b1;
                    end else begin
                        r_y <= r_y + 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            if (r_cmd == pafp_pkg::CMD_SET) begin
                o_m_tuser <= r_bad;
                o_m_tdata <= {3'd0, 16'd0, r_row[1:0], r_col[2:0]};
                o_m_tlast <= 1'b1;
            end else begin
                o_m_tuser <= 1'b0;
                o_m_tdata <= {3'd0, pafp_pkg::make_pattern(r_phase, r_duty),
                              2'(r_y), 3'(r_x)};
                o_m_tlast <= last_elem;
            end
        end
    end

    `PAFP_ASSERT_NEXT(a_stall_holds, (r_state == S_OUT) && o_m_tvalid && !i_m_tready, r_state == S_OUT, "sequencer moved during output stall")
    `PAFP_ASSERT_NOW(a_write_idle, wr_en, r_state == S_IDLE, "table write outside idle")
    `PAFP_ASSERT_NEXT(a_last_idle, out_load && (r_cmd == pafp_pkg::CMD_SET || last_elem), (r_state == S_IDLE) && o_m_tlast, "final result did not end the command")

endmodule
`default_nettype wire

### dv/testbench.sv
`default_nettype none
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] REG_UNUSED_LO = 2'd2;
    localparam logic [1:0] REG_UNUSED_HI = 2'd3;
    localparam int         STALL_LIMIT   = 20000;
    localparam int         DRAIN_CYCLES  = 100;
    localparam int         CALM_FIRST    = 20000;
    localparam int         CALM_LAST     = 26000;

    typedef struct packed {
        pafp_pkg::t_cmd cmd;
        logic [7:0] col;
        logic [7:0] row;
        logic [7:0] offv;
        logic [7:0] duty;
        logic [7:0] px;
        logic [7:0] py;
        logic [7:0] pz;
    } t_request;

    typedef struct packed {
        logic        status;
        logic [2:0]  col;
        logic [1:0]  row;
        logic [15:0] wave;
        logic        last;
    } t_pattern;

    typedef struct packed {
        t_request req;
        logic     typed;
        logic     exp_status;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_addr;
    logic [7:0]  i_cfg_wdata;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [63:0] i_s_tdata;
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [23:0] o_m_tdata;
    logic        o_m_tuser;
    logic        o_m_tlast;

    logic [7:0]  offset_copy [pafp_pkg::CELLS];
    logic [7:0]  diam_copy;
    logic [7:0]  spac_copy;
    t_pattern    pending_patterns [$];
    int          mismatches;
    int          cyc = 0;
    int          quiet_cycles;
    int          hold_cnt;

    phased_array_focus_pattern i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_wdata(i_cfg_wdata),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    function automatic longint unsigned floor_sqrt(input longint unsigned n);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n   = n - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic logic [15:0] wave_of(input logic [7:0] phase, input logic [7:0] duty);
        int unsigned nd;
        int unsigned np;
        int unsigned pat;
        nd = int'(duty) * pafp_pkg::PHASE_STEPS / 255;
        np = int'(phase) * pafp_pkg::PHASE_STEPS / 255;
        if (np + nd > pafp_pkg::PHASE_STEPS)
            pat = ~(((32'd1 << (pafp_pkg::PHASE_STEPS - nd)) - 1)
                    << (np + nd - pafp_pkg::PHASE_STEPS));
        else
            pat = ((32'd1 << nd) - 1) << np;
        return 16'(pat & ((32'd1 << pafp_pkg::PHASE_STEPS) - 1));
    endfunction

    function automatic int centre_mm(input int idx);
        return int'(diam_copy) / 2 + (int'(diam_copy) + int'(spac_copy)) * idx;
    endfunction

    // apply one accepted request to the model state and queue its patterns
    function automatic void predict_patterns(input t_request r, input logic typed,
                                             input logic exp_status);
        t_pattern        p;
        logic            bad;
        longint          dx;
        longint          dy;
        longint unsigned root;
        logic [7:0]      phase;
        if (r.cmd == pafp_pkg::CMD_NONE) return;
        if (r.cmd == pafp_pkg::CMD_SET) begin
            bad = (r.col >= pafp_pkg::COLUMNS) || (r.row >= pafp_pkg::ROWS);
            if (!bad) offset_copy[int'(r.col) * pafp_pkg::ROWS + int'(r.row)] = r.offv;
            p.status = typed ? exp_status : bad;
            p.col    = r.col[2:0];
            p.row    = r.row[1:0];
            p.wave   = '0;
            p.last   = 1'b1;
            pending_patterns.push_back(p);
            return;
        end
        for (int x = 0; x < pafp_pkg::COLUMNS; x++) begin
            for (int y = 0; y < pafp_pkg::ROWS; y++) begin
                phase = offset_copy[x * pafp_pkg::ROWS + y];
                if (r.cmd == pafp_pkg::CMD_FOCUS) begin
                    dx   = centre_mm(x) - int'(r.px);
                    dy   = centre_mm(y) - int'(r.py);
                    root = floor_sqrt(100 * longint'(dx * dx + dy * dy
                                      + int'(r.pz) * int'(r.pz)));
                    phase = 8'(root * 2550 / 860) + phase;
                end
                p.status = 1'b0;
                p.col    = 3'(x);
                p.row    = 2'(y);
                p.wave   = wave_of(phase, r.duty);
                p.last   = (x == pafp_pkg::COLUMNS - 1) && (y == pafp_pkg::ROWS - 1);
                pending_patterns.push_back(p);
            end
        end
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    always @(posedge i_clk) cyc <= cyc + 1;

    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // result side: check, then decide ready for the next cycle
    always @(posedge i_clk) begin
        t_pattern want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_patterns.size() == 0) begin
                report_mismatch("unexpected result", int'(o_m_tdata), 0);
            end else begin
                want = pending_patterns.pop_front();
                if (o_m_tuser != want.status)
                    report_mismatch("status", o_m_tuser, want.status);
                if (o_m_tdata[2:0] != want.col)
                    report_mismatch("out_column", o_m_tdata[2:0], want.col);
                if (o_m_tdata[4:3] != want.row)
                    report_mismatch("out_row", o_m_tdata[4:3], want.row);
                if (o_m_tdata[20:5] != want.wave)
                    report_mismatch("wave_pattern", o_m_tdata[20:5], want.wave);
                if (o_m_tlast != want.last)
                    report_mismatch("last", o_m_tlast, want.last);
            end
        end
        if (cyc == 2500) begin
            hold_cnt   <= 500;
            i_m_tready <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt   <= hold_cnt - 1;
            i_m_tready <= 1'b0;
        end else if (cyc >= CALM_FIRST && cyc < CALM_LAST) begin
            i_m_tready <= 1'b1;
        end else begin
            i_m_tready <= ($urandom_range(0, 99) >= 37);
        end
    end

    task automatic send_request(input t_request r, input logic typed, input logic exp_status);
        int gap;
        gap = 0;
        if (!(cyc >= CALM_FIRST && cyc < CALM_LAST))
            while ($urandom_range(0, 99) < 37 && gap < 6) gap++;
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {6'd0, r.pz, r.py, r.px, r.duty, r.offv, r.row, r.col, r.cmd};
        do @(posedge i_clk); while (!(i_s_tvalid && o_s_tready));
        predict_patterns(r, typed, exp_status);
    endtask

    task automatic write_reg(input logic [1:0] addr, input logic [7:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        if (addr == pafp_pkg::REG_DIAMETER) diam_copy = value;
        else if (addr == pafp_pkg::REG_SPACING) spac_copy = value;
    endtask

    task automatic drain_results();
        i_s_tvalid <= 1'b0;
        while (pending_patterns.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic t_request random_request();
        t_request r;
        int       pick;
        r.col  = 8'($urandom);
        r.row  = 8'($urandom);
        r.offv = 8'($urandom);
        r.duty = 8'($urandom);
        r.px   = 8'($urandom);
        r.py   = 8'($urandom);
        r.pz   = 8'($urandom);
        pick   = $urandom_range(0, 99);
        if (pick < 62) begin
            r.cmd = pafp_pkg::CMD_SET;
            if ($urandom_range(0, 99) < 80) begin
                r.col = 8'($urandom_range(0, pafp_pkg::COLUMNS - 1));
                r.row = 8'($urandom_range(0, pafp_pkg::ROWS - 1));
            end
        end else if (pick < 80) begin
            r.cmd = pafp_pkg::CMD_FOCUS;
        end else if (pick < 95) begin
            r.cmd = pafp_pkg::CMD_FLAT;
        end else begin
            r.cmd = pafp_pkg::CMD_NONE;
        end
        return r;
    endfunction

    t_row directed [15] = '{
        '{'{pafp_pkg::CMD_FLAT,  8'd0, 8'd0, 8'd0, 8'd255, 8'd0, 8'd0, 8'd0}, 1'b0, 1'b0},
        '{'{pafp_pkg::CMD_SET,   8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0}, 1'b1, 1'b0},
        '{'{pafp_pkg::CMD_SET,   8'd7, 8'd3, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255},
          1'b1, 1'b0},
        '{'{pafp_pkg::CMD_SET,   8'd3, 8'd1, 8'd128, 8'd0, 8'd0, 8'd0, 8'd0}, 1'b1, 1'b0},
        '{'{pafp_pkg::CMD_SET,   8'd8, 8'd0, 8'd77, 8'd0, 8'd0, 8'd0, 8'd0}, 1'b1, 1'b1},
        '{'{pafp_pkg::CMD_SET,   8'd0, 8'd4, 8'd77, 8'd0, 8'd0, 8'd0, 8'd0}, 1'b1, 1'b1},
        '{'{pafp_pkg::CMD_SET,   8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255},
          1'b1, 1'b1},
        '{'{pafp_pkg::CMD_NONE,  8'd1, 8'd1, 8'd9, 8'd9, 8'd9, 8'd9, 8'd9}, 1'b0, 1'b0},
        '{'{pafp_pkg::CMD_FLAT,  8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0}, 1'b0, 1'b0},
        '{'{pafp_pkg::CMD_FLAT,  8'd0, 8'd0, 8'd0, 8'd255, 8'd0, 8'd0, 8'd0}, 1'b0, 1'b0},
        '{'{pafp_pkg::CMD_FLAT,  8'd0, 8'd0, 8'd0, 8'd200, 8'd0, 8'd0, 8'd0}, 1'b0, 1'b0},
        '{'{pafp_pkg::CMD_FOCUS, 8'd0, 8'd0, 8'd0, 8'd128, 8'd0, 8'd0, 8'd0}, 1'b0, 1'b0},
        '{'{pafp_pkg::CMD_FOCUS, 8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 8'd255},
          1'b0, 1'b0},
        '{'{pafp_pkg::CMD_FOCUS, 8'd0, 8'd0, 8'd0, 8'd51, 8'd70, 8'd30, 8'd100},
          1'b0, 1'b0},
        '{'{pafp_pkg::CMD_NONE,  8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0}, 1'b0, 1'b0}
    };

    initial begin
        logic [7:0] diam_set [5];
        logic [7:0] spac_set [5];
        mismatches   = 0;
        quiet_cycles = 0;
        hold_cnt     = 0;
        diam_copy    = 8'd16;
        spac_copy    = 8'd2;
        foreach (offset_copy[k]) offset_copy[k] = '0;
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_addr  = pafp_pkg::REG_DIAMETER;
        i_cfg_wdata = '0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_m_tready  = 1'b0;
        diam_set = '{8'd16, 8'd255, 8'd0, 8'd1, 8'($urandom_range(1, 255))};
        spac_set = '{8'd2,  8'd255, 8'd0, 8'd0, 8'($urandom)};
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[k]) send_request(directed[k].req, directed[k].typed,
                                           directed[k].exp_status);
        for (int ph = 0; ph < 5; ph++) begin
            drain_results();
            write_reg(pafp_pkg::REG_DIAMETER, diam_set[ph]);
            write_reg(pafp_pkg::REG_SPACING, spac_set[ph]);
            write_reg(ph[0] ? REG_UNUSED_HI : REG_UNUSED_LO, 8'($urandom));
            i_cfg_we <= 1'b0;
            for (int n = 0; n < 96; n++) send_request(random_request(), 1'b0, 1'b0);
        end
        drain_results();

        if (mismatches == 0 && pending_patterns.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
`default_nettype wire

### files.f
+incdir+rtl
rtl/pafp_pkg.sv
rtl/pafp_isqrt.sv
rtl/phased_array_focus_pattern.sv
dv/testbench.sv
